/* rtl/assert_macros.svh */
// Assertion helpers for the primality tester.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the next clock edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mrpt_pkg.sv */
package mrpt_pkg;

  localparam int unsigned NW = 63;
  localparam int unsigned NUM_BASES = 7;
  localparam int unsigned BIDX_W = 3;
  localparam int unsigned BIT_W = 6;

  typedef logic [NW-1:0] word_t;

  // Datapath operations requested by the controller.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,  // latch n, set u = n-1
    OP_SHIFT  = 3'd2,  // u >>= 1, t++
    OP_BASE   = 3'd3,  // b = base mod n, r = 1, e = u
    OP_MULR   = 3'd4,  // r = r*b mod n
    OP_SQB    = 3'd5,  // b = b*b mod n, e >>= 1
    OP_SQX    = 3'd6   // r = r*r mod n, i++
  } op_t;

  typedef struct packed {
    op_t op;
    logic [BIDX_W-1:0] base_idx;
  } cmd_t;

  typedef struct packed {
    logic lt2;
    logic even;
    logic is2;
    logic u_odd;
    logic e_zero;
    logic e_lsb;
    logic r_pass0;    // r == 0, 1 or n-1
    logic r_one;
    logic r_nm1;
    logic i_last;     // i >= t
    logic done;       // datapath op finished
  } stat_t;

  function automatic word_t base_const(input logic [BIDX_W-1:0] k);
    word_t v;
    v = '0;
    unique case (k)
      3'd0: v = word_t'(64'd2);
      3'd1: v = word_t'(64'd235);
      3'd2: v = word_t'(64'd9375);
      3'd3: v = word_t'(64'd28178);
      3'd4: v = word_t'(64'd450775);
      3'd5: v = word_t'(64'd9780504);
      3'd6: v = word_t'(64'd1795265022);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/miller_rabin_primality_test.sv */
// Channel  | Ports                       | Handshake
// ---------+-----------------------------+-------------------------------------
// request  | start, in_candidate[62:0]   | taken when start && !busy
// result   | out_valid, out_is_prime     | one-cycle strobe, cannot be stalled
//
// One request at a time. Each modular multiply runs bit-serially in
// mrpt_modmul. A base needs at most 125 multiplies (one reduction, up to
// 62 squarings and 62 multiplies of the power), and a request tries at
// most 7 bases; even or tiny values go from the check straight to the result.
// Reset is synchronous, active low, and returns the controller to idle.
// The result strobe comes in the cycle after the verdict; busy drops with it.
`include "assert_macros.svh"

module miller_rabin_primality_test (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [62:0] in_candidate,
  output logic        out_valid,
  output logic        out_is_prime
);
  mrpt_pkg::cmd_t  cmd;
  mrpt_pkg::stat_t stat;

  // Controller: sequences decomposition of n-1, bases, exponentiation, squarings.
  mrpt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .stat(stat), .cmd(cmd),
    .busy(busy), .out_valid(out_valid), .out_is_prime(out_is_prime)
  );

  // Datapath: operand registers and the shared serial modular multiplier.
  mrpt_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_candidate(in_candidate), .cmd(cmd), .stat(stat)
  );

  // A result strobe is never back to back.
  `ASSERT_NEXT(a_ov_single, out_valid, !out_valid, "result strobe lasted two cycles")
  // An accepted request makes the block busy next cycle.
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request not taken")
  // The result is only produced once the block is no longer busy.
  `ASSERT_CLK(a_ov_busy, !out_valid || !busy, "result while still busy")
endmodule

/* rtl/mrpt_modmul.sv */
// Bit-serial modular multiply, one bit of y per cycle, MSB first.
// Also used as a modular reducer: 1*y mod m.
module mrpt_modmul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  mrpt_pkg::word_t  x,
  input  mrpt_pkg::word_t  y,
  input  mrpt_pkg::word_t  m,
  output logic             done,
  output mrpt_pkg::word_t  p
);
  logic                      busy_r, busy_nxt;
  logic [mrpt_pkg::BIT_W-1:0] bit_r, bit_nxt;
  mrpt_pkg::word_t           x_r, y_r, m_r;
  logic [mrpt_pkg::NW:0]     acc_r, acc_nxt;
  logic [mrpt_pkg::NW:0]     dbl, dbl_m, add, add_m;
  logic                      done_r, done_nxt;

  always_comb begin
    dbl   = {acc_r[mrpt_pkg::NW-1:0], 1'b0};
    dbl_m = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    add   = dbl_m + {1'b0, x_r};
    add_m = (add >= {1'b0, m_r}) ? add - {1'b0, m_r} : add;
    busy_nxt = busy_r;
    bit_nxt  = bit_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (go) begin
      busy_nxt = 1'b1;
      bit_nxt  = mrpt_pkg::BIT_W'(mrpt_pkg::NW - 1);
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = y_r[bit_r] ? add_m : dbl_m;
      bit_nxt = bit_r - 1'b1;
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bit_r <= bit_nxt;
    acc_r <= acc_nxt;
    if (go) begin
      x_r <= x;
      y_r <= y;
      m_r <= m;
    end
  end

  assign done = done_r;
  assign p    = acc_r[mrpt_pkg::NW-1:0];
endmodule

/* rtl/mrpt_datapath.sv */
module mrpt_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  mrpt_pkg::word_t  in_candidate,
  input  mrpt_pkg::cmd_t   cmd,
  output mrpt_pkg::stat_t  stat
);
  mrpt_pkg::word_t n_r, u_r, e_r, b_r, r_r;
  logic [mrpt_pkg::BIT_W-1:0] t_r, i_r;
  mrpt_pkg::op_t   pend_r;
  logic            go;
  mrpt_pkg::word_t mx, my, mp;
  logic            mdone;

  function automatic mrpt_pkg::word_t u_r_nm1(input mrpt_pkg::word_t nv);
    return nv - 1'b1;
  endfunction

  mrpt_modmul u_mul (
    .clk(clk), .rst_n(rst_n), .go(go), .x(mx), .y(my), .m(n_r),
    .done(mdone), .p(mp)
  );

  // Base reduction runs as 1 * base mod n: the base walks the y bits,
  // so it may exceed n while x stays below n.
  always_comb begin
    go = 1'b0;
    mx = r_r;
    my = b_r;
    unique case (cmd.op)
      mrpt_pkg::OP_BASE: begin
        go = 1'b1; mx = mrpt_pkg::word_t'(1);
        my = mrpt_pkg::base_const(cmd.base_idx);
      end
      mrpt_pkg::OP_MULR: begin go = 1'b1; mx = r_r; my = b_r; end
      mrpt_pkg::OP_SQB:  begin go = 1'b1; mx = b_r; my = b_r; end
      mrpt_pkg::OP_SQX:  begin go = 1'b1; mx = r_r; my = r_r; end
      default: go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= mrpt_pkg::OP_NONE;
    end else begin
      if (go) pend_r <= cmd.op;
      else if (mdone) pend_r <= mrpt_pkg::OP_NONE;
    end
    unique case (cmd.op)
      mrpt_pkg::OP_LOAD: begin
        n_r <= in_candidate;
        u_r <= in_candidate - 1'b1;
        t_r <= '0;
      end
      mrpt_pkg::OP_SHIFT: begin
        u_r <= u_r >> 1;
        t_r <= t_r + 1'b1;
      end
      mrpt_pkg::OP_BASE: begin
        r_r <= mrpt_pkg::word_t'(1);
        e_r <= u_r;
        i_r <= mrpt_pkg::BIT_W'(1);
      end
      default: ;
    endcase
    if (mdone) begin
      unique case (pend_r)
        mrpt_pkg::OP_BASE: b_r <= mp;
        mrpt_pkg::OP_MULR: r_r <= mp;
        mrpt_pkg::OP_SQB: begin b_r <= mp; e_r <= e_r >> 1; end
        mrpt_pkg::OP_SQX: begin r_r <= mp; i_r <= i_r + 1'b1; end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.lt2     = (n_r < mrpt_pkg::word_t'(2));
    stat.even    = ~n_r[0];
    stat.is2     = (n_r == mrpt_pkg::word_t'(2));
    stat.u_odd   = u_r[0];
    stat.e_zero  = (e_r == '0);
    stat.e_lsb   = e_r[0];
    stat.r_one   = (r_r == mrpt_pkg::word_t'(1));
    stat.r_nm1   = (r_r == u_r_nm1(n_r));
    stat.r_pass0 = (r_r == '0) || stat.r_one || stat.r_nm1;
    stat.i_last  = (i_r >= t_r);
    stat.done    = mdone;
  end
endmodule

/* rtl/mrpt_ctrl.sv */
module mrpt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  mrpt_pkg::stat_t  stat,
  output mrpt_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             out_valid,
  output logic             out_is_prime
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHK   = 9'b000000010,
    S_SPLIT = 9'b000000100,
    S_BASE  = 9'b000001000,
    S_EXP   = 9'b000010000,
    S_WAIT  = 9'b000100000,
    S_TEST  = 9'b001000000,
    S_SQ    = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [mrpt_pkg::BIDX_W-1:0] k_r, k_nxt;
  logic mulr_r, mulr_nxt;      // in EXP: multiply step pending before squaring
  logic sqx_r, sqx_nxt;        // waiting on an x squaring
  logic res_r, res_nxt;
  logic ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    mulr_nxt = mulr_r;
    sqx_nxt = sqx_r;
    res_nxt = res_r;
    ov_nxt = 1'b0;
    cmd.op = mrpt_pkg::OP_NONE;
    cmd.base_idx = k_r;
    unique case (state_r)
      S_IDLE: if (start) begin
        cmd.op = mrpt_pkg::OP_LOAD;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.lt2 || stat.even) begin
          res_nxt = stat.is2;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (stat.u_odd) begin
          k_nxt = '0;
          state_nxt = S_BASE;
        end else begin
          cmd.op = mrpt_pkg::OP_SHIFT;
        end
      end
      S_BASE: begin
        cmd.op = mrpt_pkg::OP_BASE;
        mulr_nxt = 1'b1;
        sqx_nxt = 1'b0;
        state_nxt = S_WAIT;
      end
      S_EXP: begin
        if (stat.e_zero) begin
          state_nxt = S_TEST;
        end else if (mulr_r && stat.e_lsb) begin
          cmd.op = mrpt_pkg::OP_MULR;
          mulr_nxt = 1'b0;
          state_nxt = S_WAIT;
        end else begin
          cmd.op = mrpt_pkg::OP_SQB;
          mulr_nxt = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: if (stat.done) begin
        state_nxt = sqx_r ? S_SQ : S_EXP;
      end
      S_TEST: begin
        if (stat.r_pass0) begin
          if (k_r == mrpt_pkg::BIDX_W'(mrpt_pkg::NUM_BASES - 1)) begin
            res_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            k_nxt = k_r + 1'b1;
            state_nxt = S_BASE;
          end
        end else if (stat.i_last) begin
          res_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          cmd.op = mrpt_pkg::OP_SQX;
          sqx_nxt = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_SQ: begin
        if (stat.r_one) begin
          res_nxt = 1'b0;
          state_nxt = S_DONE;
        end else if (stat.r_nm1) begin
          if (k_r == mrpt_pkg::BIDX_W'(mrpt_pkg::NUM_BASES - 1)) begin
            res_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            k_nxt = k_r + 1'b1;
            state_nxt = S_BASE;
          end
        end else if (stat.i_last) begin
          res_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          cmd.op = mrpt_pkg::OP_SQX;
          state_nxt = S_WAIT;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
    k_r <= k_nxt;
    mulr_r <= mulr_nxt;
    sqx_r <= sqx_nxt;
    res_r <= res_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_is_prime = res_r;
endmodule

/* tb/tb_miller_rabin_primality_test.sv */
module tb_miller_rabin_primality_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Watchdog limit for the whole run. Most random requests use
  // small values, so real runs are far shorter than this bound.
  localparam longint unsigned CYCLE_LIMIT = 64'd30_000_000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [62:0] in_candidate;
  logic        out_valid;
  logic        out_is_prime;

  miller_rabin_primality_test dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_candidate(in_candidate),
    .out_valid   (out_valid),
    .out_is_prime(out_is_prime)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Verdicts still owed by the block, oldest first.
  bit              pending_verdicts[$];
  int              fail_count;
  longint unsigned cycle_count;
  int              burst_left;

  // ---------------------------------------------------------------------
  // Primality predictor
  // ---------------------------------------------------------------------
  // Exact product, reduced modulo m.
  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y,
                                         logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, x} * {64'd0, y};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e,
                                         logic [63:0] m);
    logic [63:0] acc;
    acc = (m == 64'd1) ? 64'd0 : 64'd1;
    while (e != 64'd0) begin
      if (e[0]) acc = mulmod(acc, b, m);
      b = mulmod(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // Strong-probable-prime check of n for one witness.
  function automatic bit witness_passes(logic [63:0] w, logic [63:0] odd_part,
                                        int twos, logic [63:0] n);
    logic [63:0] x;
    x = powmod(w % n, odd_part, n);
    if (x == 64'd0 || x == 64'd1 || x == n - 64'd1) return 1'b1;
    for (int i = 1; i < twos; i++) begin
      x = mulmod(x, x, n);
      if (x == 64'd1) return 1'b0;      // nontrivial root of one
      if (x == n - 64'd1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit predict_prime(logic [62:0] cand);
    logic [63:0] witnesses [7];
    logic [63:0] n;
    logic [63:0] odd_part;
    int          twos;
    witnesses = '{64'd2, 64'd235, 64'd9375, 64'd28178, 64'd450775,
                  64'd9780504, 64'd1795265022};
    n = {1'b0, cand};
    if (n < 64'd2) return 1'b0;
    if (!n[0]) return n == 64'd2;
    odd_part = n - 64'd1;
    twos = 0;
    while (!odd_part[0]) begin
      odd_part = odd_part >> 1;
      twos++;
    end
    foreach (witnesses[k])
      if (!witness_passes(witnesses[k], odd_part, twos, n)) return 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------
  // Holds start until the block takes the request. Start stays high across
  // a burst; a gap lowers it for a random number of cycles.
  task automatic send_candidate(logic [62:0] cand);
    int gap;
    start        <= 1'b1;
    in_candidate <= cand;
    do @(posedge clk); while (busy);
    pending_verdicts.push_back(predict_prime(cand));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 5);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checker: every strobe must match the oldest pending verdict.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: is_prime=%0b with no request pending", out_is_prime);
        fail_count++;
      end else begin
        bit want;
        want = pending_verdicts.pop_front();
        if (out_is_prime !== want) begin
          $error("is_prime mismatch: expected %0b, actual %0b", want, out_is_prime);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("miller_rabin_primality_test verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Edge values, small primes, pseudoprimes and the widest operands.
  task automatic test_directed();
    logic [62:0] picks [$];
    picks = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4,
              63'd5,          // 235 is a multiple of n: power is zero
              63'd7, 63'd9,
              63'd561,        // Carmichael: square hits one early
              63'd2047,       // fools base 2 alone
              63'd3215031751, // fools bases 2,3,5,7
              63'd1795265022, 63'd1795265023,
              63'h1FFF_FFFF_FFFF_FFFF,  // Mersenne prime 2^61-1
              63'd9223372036854775783,  // largest 63-bit prime
              63'h7FFF_FFFF_FFFF_FFFF,  // all ones, composite
              63'h4000_0000_0000_0000,
              63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAB};
    foreach (picks[i]) send_candidate(picks[i]);
  endtask

  // Small values keep the exponent short; plenty of primes turn up here.
  task automatic test_small_random();
    repeat (85) send_candidate(63'($urandom_range(0, 65535)));
  endtask

  // A few full-width values, mostly odd, so every input bit toggles.
  task automatic test_full_random();
    logic [62:0] v;
    repeat (15) begin
      v = 63'({$urandom, $urandom});
      if ($urandom_range(0, 3) != 0) v[0] = 1'b1;
      send_candidate(v);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_candidate = '0;
    fail_count   = 0;
    cycle_count  = 0;
    burst_left   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_small_random();
    test_full_random();

    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("miller_rabin_primality_test verification clean");
    end else begin
      $display("miller_rabin_primality_test verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/mrpt_pkg.sv
rtl/mrpt_modmul.sv
rtl/mrpt_datapath.sv
rtl/mrpt_ctrl.sv
rtl/miller_rabin_primality_test.sv
tb/tb_miller_rabin_primality_test.sv
